@@ src/btf_pkg.sv @@
// Shared types, widths, register codes and reset values of the barometric trend forecaster.
package btf_pkg;

  // Field widths
  localparam int PRESS_W    = 18;
  localparam int TEMP_W     = 11;
  localparam int RATE_W     = 10;
  localparam int PLIM_W     = 18;
  localparam int FC_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // Window schedule
  localparam int WINDOW_SPACING    = 30;
  localparam int UNITS_PER_SPACING = 5;
  localparam int POS_W             = 5;

  // Parameter defaults
  localparam int WINDOW_SAMPLES_DEF = 6;
  localparam int WINDOW_COUNT_DEF   = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STORM_PRES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAIN_PRES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIR_PRES  = 3'd4;

  // Register reset values
  localparam logic [RATE_W-1:0] FAST_RATE_RST  = 10'd25;
  localparam logic [RATE_W-1:0] SLOW_RATE_RST  = 10'd5;
  localparam logic [PLIM_W-1:0] STORM_PRES_RST = 18'd98000;
  localparam logic [PLIM_W-1:0] RAIN_PRES_RST  = 18'd99500;
  localparam logic [PLIM_W-1:0] FAIR_PRES_RST  = 18'd102900;

  // Forecast codes; unknown doubles as the boundary class
  typedef enum logic [FC_W-1:0] {
    FC_UNKNOWN    = 3'd0,
    FC_STABLE     = 3'd1,
    FC_SUNNY      = 3'd2,
    FC_UNSTABLE   = 3'd3,
    FC_RAIN       = 3'd4,
    FC_HEAVY_RAIN = 3'd5,
    FC_SNOW       = 3'd6
  } forecast_t;

  // Tendency thresholds handed to the classifier
  typedef struct packed {
    logic [RATE_W-1:0] fast;
    logic [RATE_W-1:0] slow;
  } rate_lim_t;

endpackage

@@ src/btf_cell.sv @@
// One cell of the window sum chain: holds a closed window sum and passes it down the chain.
module btf_cell #(
  parameter int SUM_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             shift,
  input  logic [SUM_W-1:0] acc,
  input  logic [SUM_W-1:0] shift_in,
  output logic [SUM_W-1:0] pass_out,
  output logic [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  // Offer the value this cell holds once the current write has landed
  assign pass_out = load ? acc : sum_r;
  assign sum      = sum_r;

  // Take the neighbour's sum on a chain shift, else capture a closing window
  always_comb begin
    if (shift) begin
      sum_nxt = shift_in;
    end else if (load) begin
      sum_nxt = acc;
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

@@ src/btf_tendency.sv @@
// Tendency classifier: compares a window sum difference against scaled rate thresholds.
module btf_tendency #(
  parameter int WINDOW_SAMPLES = btf_pkg::WINDOW_SAMPLES_DEF,
  parameter int WINDOW_COUNT   = btf_pkg::WINDOW_COUNT_DEF,
  parameter int SUM_W          = 21
) (
  input  logic signed [SUM_W:0]              diff,
  input  logic [$clog2(WINDOW_COUNT)-1:0]    idx,
  input  btf_pkg::rate_lim_t                 lim,
  output btf_pkg::forecast_t                 cls
);

  localparam int UNIT_STEP = WINDOW_SAMPLES * btf_pkg::UNITS_PER_SPACING;
  localparam int MAX_SCALE = UNIT_STEP * (WINDOW_COUNT - 1);
  localparam int SCALE_W   = $clog2(MAX_SCALE + 1);
  localparam int TH_W      = SCALE_W + btf_pkg::RATE_W;
  localparam int DIFF_W    = SUM_W + 1;
  localparam int CW        = ((DIFF_W > TH_W + 1) ? DIFF_W : TH_W + 1) + 1;

  logic [SCALE_W-1:0] scale;
  logic [TH_W-1:0]    th_fast;
  logic [TH_W-1:0]    th_slow;
  logic signed [CW-1:0] d;
  logic signed [CW-1:0] pf;
  logic signed [CW-1:0] ps;
  logic signed [CW-1:0] nf;
  logic signed [CW-1:0] ns;

  // Scale the thresholds by the window distance
  assign scale   = SCALE_W'(idx) * SCALE_W'(UNIT_STEP);
  assign th_fast = TH_W'(scale) * TH_W'(lim.fast);
  assign th_slow = TH_W'(scale) * TH_W'(lim.slow);

  assign d  = CW'(diff);
  assign pf = $signed(CW'(th_fast));
  assign ps = $signed(CW'(th_slow));
  assign nf = -pf;
  assign ns = -ps;

  // Ordered compares: fast fall, fast rise, slow fall, slow rise, stable, else boundary
  always_comb begin
    if (d < nf) begin
      cls = btf_pkg::FC_HEAVY_RAIN;
    end else if (d > pf) begin
      cls = btf_pkg::FC_UNSTABLE;
    end else if (d > nf && d < ns) begin
      cls = btf_pkg::FC_RAIN;
    end else if (d > ps && d < pf) begin
      cls = btf_pkg::FC_SUNNY;
    end else if (d > ns && d < ps) begin
      cls = btf_pkg::FC_STABLE;
    end else begin
      cls = btf_pkg::FC_UNKNOWN;
    end
  end

endmodule

@@ src/barometric_trend_forecaster_top.sv @@
// Top level of the barometric trend forecaster: schedule, window chain and forecast stage.
//
//  channel | direction | handshake                  | payload
//  in_     | input     | in_tvalid / in_tready      | in_tdata: pressure, temperature
//  out_    | output    | out_tvalid / out_tready    | out_tdata: forecast
//  cfg_    | input     | cfg_we                     | cfg_index, cfg_data
//
// One sample per cycle sustained while out_tready is high; each input transfer is accumulated
// into the middle stage, then classified into the output register and offered on out_.
// Reset (synchronous, rst_n low) clears the schedule, window sums, class and limits to defaults.
// A stalled output holds the output register; the middle stage still takes one more sample,
// and in_tready falls only when both stages are full and out_tready is low.
module barometric_trend_forecaster_top #(
  parameter int WINDOW_SAMPLES = btf_pkg::WINDOW_SAMPLES_DEF,
  parameter int WINDOW_COUNT   = btf_pkg::WINDOW_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [btf_pkg::IN_DATA_W-1:0]     in_tdata,   // [17:0] pressure, [28:18] temperature
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [btf_pkg::OUT_DATA_W-1:0]    out_tdata,  // [2:0] forecast
  input  logic                              cfg_we,
  input  logic [btf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W   = $clog2(WINDOW_COUNT);
  localparam int POS_W   = btf_pkg::POS_W;
  localparam int PRESS_W = btf_pkg::PRESS_W;
  localparam int SUM_W   = PRESS_W + $clog2(WINDOW_SAMPLES);

  // Configuration registers
  logic [btf_pkg::RATE_W-1:0] fast_rate_r;
  logic [btf_pkg::RATE_W-1:0] slow_rate_r;
  logic [btf_pkg::PLIM_W-1:0] storm_pres_r;
  logic [btf_pkg::PLIM_W-1:0] rain_pres_r;
  logic [btf_pkg::PLIM_W-1:0] fair_pres_r;

  // Schedule and accumulation
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_nxt;
  logic [SUM_W-1:0] acc_sum;
  logic [PRESS_W-1:0] in_press;
  logic in_frz;
  logic in_acc;
  logic in_win;
  logic win_close;
  logic last_close;
  logic warm_nxt;
  logic signed [SUM_W:0] diff;

  // Window chain
  logic [SUM_W-1:0] cell_sum  [WINDOW_COUNT];
  logic [SUM_W-1:0] cell_pass [WINDOW_COUNT];

  // Middle stage
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic s1_close_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic signed [SUM_W:0] s1_diff_r;
  logic [PRESS_W-1:0] s1_press_r;
  logic s1_frz_r;
  logic s1_warm_r;

  // Classification and output
  btf_pkg::rate_lim_t lim;
  btf_pkg::forecast_t tend_cls;
  btf_pkg::forecast_t class_r;
  btf_pkg::forecast_t class_nxt;
  btf_pkg::forecast_t fc;
  btf_pkg::forecast_t out_fc_r;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_load;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_rate_r  <= btf_pkg::FAST_RATE_RST;
      slow_rate_r  <= btf_pkg::SLOW_RATE_RST;
      storm_pres_r <= btf_pkg::STORM_PRES_RST;
      rain_pres_r  <= btf_pkg::RAIN_PRES_RST;
      fair_pres_r  <= btf_pkg::FAIR_PRES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        btf_pkg::CFG_FAST_RATE:  fast_rate_r  <= cfg_data[btf_pkg::RATE_W-1:0];
        btf_pkg::CFG_SLOW_RATE:  slow_rate_r  <= cfg_data[btf_pkg::RATE_W-1:0];
        btf_pkg::CFG_STORM_PRES: storm_pres_r <= cfg_data[btf_pkg::PLIM_W-1:0];
        btf_pkg::CFG_RAIN_PRES:  rain_pres_r  <= cfg_data[btf_pkg::PLIM_W-1:0];
        btf_pkg::CFG_FAIR_PRES:  fair_pres_r  <= cfg_data[btf_pkg::PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  // Unpack the input transfer
  assign in_press = in_tdata[PRESS_W-1:0];
  assign in_frz   = in_tdata[PRESS_W + btf_pkg::TEMP_W - 1];

  // Accumulate the open window
  assign in_win     = pos_r < POS_W'(WINDOW_SAMPLES);
  assign win_close  = in_win && (pos_r == POS_W'(WINDOW_SAMPLES - 1));
  assign last_close = win_close && (idx_r == IDX_W'(WINDOW_COUNT - 1));
  assign acc_sum    = (pos_r == '0) ? SUM_W'(in_press) : acc_r + SUM_W'(in_press);
  assign acc_nxt    = in_win ? acc_sum : acc_r;
  assign diff       = $signed({1'b0, acc_sum}) - $signed({1'b0, cell_sum[0]});

  // Advance the minute schedule; step back one window after the last one closes
  always_comb begin
    if (last_close) begin
      idx_nxt = IDX_W'(WINDOW_COUNT - 2);
      pos_nxt = POS_W'(WINDOW_SAMPLES);
    end else if (pos_r == POS_W'(btf_pkg::WINDOW_SPACING - 1)) begin
      idx_nxt = idx_r + 1'b1;
      pos_nxt = '0;
    end else begin
      idx_nxt = idx_r;
      pos_nxt = pos_r + 1'b1;
    end
  end

  // Forecasts start once the second window has closed
  assign warm_nxt = !((idx_nxt == '0) ||
                      ((idx_nxt == IDX_W'(1)) && (pos_nxt < POS_W'(WINDOW_SAMPLES))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pos_r <= '0;
      acc_r <= '0;
    end else if (in_acc) begin
      idx_r <= idx_nxt;
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Chain of window sum cells
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_COUNT; gi++) begin : g_cell
      logic [SUM_W-1:0] shift_src;
      if (gi == WINDOW_COUNT - 1) begin : g_top
        assign shift_src = acc_sum;
      end else begin : g_mid
        assign shift_src = cell_pass[gi + 1];
      end
      btf_cell #(
        .SUM_W (SUM_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_acc && win_close && (idx_r == IDX_W'(gi))),
        .shift    (in_acc && last_close),
        .acc      (acc_sum),
        .shift_in (shift_src),
        .pass_out (cell_pass[gi]),
        .sum      (cell_sum[gi])
      );
    end
  endgenerate

  // Middle stage valid
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Middle stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_close_r <= win_close && (idx_r != '0);
      s1_idx_r   <= idx_r;
      s1_diff_r  <= diff;
      s1_press_r <= in_press;
      s1_frz_r   <= in_frz;
      s1_warm_r  <= warm_nxt;
    end
  end

  // Classify the tendency of a closing window
  assign lim.fast = fast_rate_r;
  assign lim.slow = slow_rate_r;

  btf_tendency #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .WINDOW_COUNT   (WINDOW_COUNT),
    .SUM_W          (SUM_W)
  ) u_tendency (
    .diff (s1_diff_r),
    .idx  (s1_idx_r),
    .lim  (lim),
    .cls  (tend_cls)
  );

  assign class_nxt = s1_close_r ? tend_cls : class_r;

  // Form the forecast: boundary fallback on pressure, then snow below zero
  always_comb begin
    fc = btf_pkg::FC_UNKNOWN;
    if (s1_warm_r) begin
      fc = class_nxt;
      if (class_nxt == btf_pkg::FC_UNKNOWN) begin
        if (s1_press_r <= storm_pres_r) begin
          fc = btf_pkg::FC_HEAVY_RAIN;
        end else if (s1_press_r <= rain_pres_r) begin
          fc = btf_pkg::FC_RAIN;
        end else if (s1_press_r >= fair_pres_r) begin
          fc = btf_pkg::FC_SUNNY;
        end
      end
      if (s1_frz_r && (fc == btf_pkg::FC_RAIN || fc == btf_pkg::FC_HEAVY_RAIN)) begin
        fc = btf_pkg::FC_SNOW;
      end
    end
  end

  // Output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      class_r     <= btf_pkg::FC_UNKNOWN;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        class_r <= class_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fc_r <= fc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = btf_pkg::OUT_DATA_W'(out_fc_r);

  // Schedule position never passes the window spacing
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(btf_pkg::WINDOW_SPACING))
    else $error("schedule position out of range");

  // Full pipeline with a stalled output refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full");

  // Stored class moves only when a sample transfers to the output register
  a_class_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(class_r))
    else $error("tendency class changed without a transfer");

  // During warm up the forecast is unknown
  a_warm_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !s1_warm_r) |=> (out_fc_r == btf_pkg::FC_UNKNOWN))
    else $error("forecast given before warm up ended");

endmodule

@@ verif/btf_checker.sv @@
// Forecast checker: tracks the window schedule, predicts every forecast and compares transfers.
module btf_forecast_checker
  import btf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [17:0] pressure, [28:18] temperature
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] forecast
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF;
  localparam int WINDOW_COUNT   = WINDOW_COUNT_DEF;
  localparam int REPORT_LIMIT   = 10;

  // Local copy of the limit registers
  logic [RATE_W-1:0] fast_lim;
  logic [RATE_W-1:0] slow_lim;
  logic [PLIM_W-1:0] storm_lim;
  logic [PLIM_W-1:0] rain_lim;
  logic [PLIM_W-1:0] fair_lim;

  // Window schedule and stored tendency
  int unsigned minute_pos;
  int unsigned win_acc;
  int unsigned win_sum [WINDOW_COUNT];
  forecast_t   trend_class;

  forecast_t forecast_q [$];
  int        mismatches = 0;
  int        result_no  = 0;

  // Ordered compares of the sum difference against scaled thresholds, no division
  function automatic forecast_t rate_class(input longint diff, input longint scale);
    longint fast_thr;
    longint slow_thr;
    fast_thr = scale * longint'(fast_lim);
    slow_thr = scale * longint'(slow_lim);
    if (diff < -fast_thr) return FC_HEAVY_RAIN;
    if (diff > fast_thr) return FC_UNSTABLE;
    if (diff > -fast_thr && diff < -slow_thr) return FC_RAIN;
    if (diff > slow_thr && diff < fast_thr) return FC_SUNNY;
    if (diff > -slow_thr && diff < slow_thr) return FC_STABLE;
    return FC_UNKNOWN;
  endfunction

  // Advance one minute and form the forecast for this sample
  function automatic forecast_t predict_forecast(input logic [PRESS_W-1:0] press,
                                                 input logic freezing);
    int unsigned c;
    int unsigned idx;
    int unsigned pos;
    forecast_t   f;
    c   = minute_pos;
    idx = c / WINDOW_SPACING;
    pos = c % WINDOW_SPACING;
    if (idx < WINDOW_COUNT && pos < WINDOW_SAMPLES) begin
      win_acc = (pos == 0) ? press : win_acc + press;
      if (pos == WINDOW_SAMPLES - 1) begin
        win_sum[idx] = win_acc;
        if (idx > 0) begin
          trend_class = rate_class(longint'(win_sum[idx]) - longint'(win_sum[0]),
                                   longint'(WINDOW_SAMPLES * UNITS_PER_SPACING)
                                   * longint'(idx));
        end
        // Last window closed: drop the oldest sum and step back one spacing
        if (idx == WINDOW_COUNT - 1) begin
          for (int i = 0; i < WINDOW_COUNT - 1; i++) win_sum[i] = win_sum[i+1];
          c = c - WINDOW_SPACING;
        end
      end
    end
    c = c + 1;
    minute_pos = c;

    if (c < WINDOW_SPACING + WINDOW_SAMPLES) begin
      f = FC_UNKNOWN;
    end else begin
      f = trend_class;
      // Tendency on a threshold: fall back to the pressure limits
      if (f == FC_UNKNOWN) begin
        if (press <= storm_lim) f = FC_HEAVY_RAIN;
        else if (press <= rain_lim) f = FC_RAIN;
        else if (press >= fair_lim) f = FC_SUNNY;
      end
      if (freezing && (f == FC_RAIN || f == FC_HEAVY_RAIN)) f = FC_SNOW;
    end
    return f;
  endfunction

  // Follow reset, register writes and both channels; compare each result transfer
  always @(posedge clk) begin : track
    forecast_t want;
    if (!rst_n) begin
      fast_lim    = FAST_RATE_RST;
      slow_lim    = SLOW_RATE_RST;
      storm_lim   = STORM_PRES_RST;
      rain_lim    = RAIN_PRES_RST;
      fair_lim    = FAIR_PRES_RST;
      minute_pos  = 0;
      win_acc     = 0;
      trend_class = FC_UNKNOWN;
      for (int i = 0; i < WINDOW_COUNT; i++) win_sum[i] = 0;
      forecast_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FAST_RATE:  fast_lim  = cfg_data[RATE_W-1:0];
          CFG_SLOW_RATE:  slow_lim  = cfg_data[RATE_W-1:0];
          CFG_STORM_PRES: storm_lim = cfg_data[PLIM_W-1:0];
          CFG_RAIN_PRES:  rain_lim  = cfg_data[PLIM_W-1:0];
          CFG_FAIR_PRES:  fair_lim  = cfg_data[PLIM_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        forecast_q.push_back(predict_forecast(in_tdata[PRESS_W-1:0],
                                              in_tdata[PRESS_W+TEMP_W-1]));
      end
      if (out_tvalid && out_tready) begin
        result_no++;
        if (forecast_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("forecast transfer %0d with nothing expected: got %0d",
                     result_no, out_tdata);
        end else begin
          want = forecast_q.pop_front();
          if (out_tdata !== {{(OUT_DATA_W-FC_W){1'b0}}, want}) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("forecast transfer %0d: expected %0d, got %0d",
                       result_no, want, out_tdata);
          end
        end
      end
    end
    outstanding <= forecast_q.size();
    fail_count  <= mismatches;
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: drives samples, limit writes and result back-pressure, and gives the verdict.
module tb_top;
  import btf_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int PHASES        = 8;
  localparam int PRESS_MAX     = (1 << PRESS_W) - 1;

  typedef enum int {SEG_TREND, SEG_STEP, SEG_FLAT, SEG_NOISE} segment_kind_t;
  typedef enum int {TEMP_MIXED, TEMP_COLD, TEMP_MILD} temp_kind_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [17:0] pressure, [28:18] temperature
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [2:0] forecast
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // Limits currently programmed, used to aim pressure steps at the thresholds
  int fast_now  = FAST_RATE_RST;
  int slow_now  = SLOW_RATE_RST;
  int storm_now = STORM_PRES_RST;
  int rain_now  = RAIN_PRES_RST;
  int fair_now  = FAIR_PRES_RST;

  bit src_burst     = 1'b0;
  bit rx_calm       = 1'b0;
  int rx_stall_left = 0;
  int rx_draw;

  int dir_press [10] = '{0, 262143, 200000, 1, 131072, 87381, 174762, 98000, 99500, 102900};
  int dir_temp  [10] = '{-1024, 1023, -600, 1000, -1, 0, 341, -342, 1, -2};

  barometric_trend_forecaster_top u_top (.*);

  btf_forecast_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: hold off for a drawn number of cycles after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready    <= 1'b0;
      rx_stall_left <= 0;
    end else if (out_tready && out_tvalid) begin
      if ($urandom_range(0, 63) == 0) rx_calm <= !rx_calm;
      rx_draw = rx_calm ? 0 : $urandom_range(0, 9);
      if (rx_draw > 0) begin
        out_tready    <= 1'b0;
        rx_stall_left <= rx_draw - 1;
      end
    end else if (!out_tready) begin
      if (rx_stall_left == 0) out_tready <= 1'b1;
      else rx_stall_left <= rx_stall_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Program all limits; rate writes carry random bits above the register width
  task automatic apply_setting(input int fast, input int slow, input int storm,
                               input int rain, input int fair, input bit spare);
    write_reg(CFG_FAST_RATE, fast | ($urandom_range(0, 255) << RATE_W));
    write_reg(CFG_SLOW_RATE, slow | ($urandom_range(0, 255) << RATE_W));
    write_reg(CFG_STORM_PRES, storm);
    write_reg(CFG_RAIN_PRES, rain);
    write_reg(CFG_FAIR_PRES, fair);
    // Unused indexes must leave every limit alone
    if (spare) begin
      for (int k = CFG_FAIR_PRES + 1; k < (1 << CFG_IDX_W); k++)
        write_reg(k[CFG_IDX_W-1:0], $urandom_range(0, PRESS_MAX));
    end
    cfg_we    <= 1'b0;
    fast_now  = fast;
    slow_now  = slow;
    storm_now = storm;
    rain_now  = rain;
    fair_now  = fair;
  endtask

  task automatic send_sample(input int press, input int temp);
    int               gap;
    logic [PRESS_W-1:0] p;
    logic [TEMP_W-1:0]  t;
    p   = PRESS_W'(press);
    t   = TEMP_W'(temp);
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-PRESS_W-TEMP_W){1'b0}}, t, p};
    do begin
      @(posedge clk);
    end while (!in_tready);
  endtask

  // Stop sending and let every forecast drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pressure level near a limit edge, or a plain weather value
  function automatic int pick_level();
    case ($urandom_range(0, 7))
      0:       return storm_now;
      1:       return storm_now + 1;
      2:       return rain_now;
      3:       return rain_now + 1;
      4:       return fair_now - 1;
      5:       return fair_now;
      default: return $urandom_range(90000, 110000);
    endcase
  endfunction

  // One stretch of weather: trend, step onto a threshold, flat level or noise
  task automatic run_segment(input int n);
    int            roll;
    segment_kind_t kind;
    temp_kind_t    tkind;
    int            base;
    int            slope;
    int            delta;
    int            step_at;
    int            p;
    int            t;
    roll = $urandom_range(0, 9);
    if (roll < 5) kind = SEG_TREND;
    else if (roll < 7) kind = SEG_STEP;
    else if (roll < 9) kind = SEG_FLAT;
    else kind = SEG_NOISE;
    tkind     = temp_kind_t'($urandom_range(0, 2));
    base      = pick_level();
    slope     = int'($urandom_range(0, 80)) - 40;
    // A step of 5*k*limit lands the difference exactly on a threshold
    delta     = 5 * int'($urandom_range(1, WINDOW_COUNT_DEF - 1))
                * (($urandom_range(0, 1) != 0) ? fast_now : slow_now);
    if ($urandom_range(0, 1) != 0) delta = -delta;
    step_at   = $urandom_range(1, n - 1);
    src_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        SEG_TREND: p = base + (slope * i) / 8 + int'($urandom_range(0, 3));
        SEG_STEP:  p = (i < step_at) ? base : base + delta;
        SEG_FLAT:  p = base;
        default:   p = $urandom_range(0, PRESS_MAX);
      endcase
      if (p < 0) p = 0;
      if (p > PRESS_MAX) p = PRESS_MAX;
      case (tkind)
        TEMP_COLD: t = -int'($urandom_range(1, 1024));
        TEMP_MILD: t = $urandom_range(0, 1023);
        default:   t = $urandom_range(0, 2047);
      endcase
      send_sample(p, t);
    end
  endtask

  task automatic select_setting(input int phase);
    case (phase)
      0: apply_setting(FAST_RATE_RST, SLOW_RATE_RST, STORM_PRES_RST, RAIN_PRES_RST,
                       FAIR_PRES_RST, 1'b0);
      1: apply_setting(0, 0, 99000, 100000, 101000, 1'b1);
      2: apply_setting(1023, 1023, 0, 0, PRESS_MAX, 1'b0);
      3: apply_setting(5, 25, STORM_PRES_RST, RAIN_PRES_RST, FAIR_PRES_RST, 1'b0);
      4: apply_setting(1, 1000, PRESS_MAX, PRESS_MAX, 0, 1'b1);
      5: apply_setting(1000, 1, 100000, 100000, 100000, 1'b0);
      6: apply_setting($urandom_range(1, 1000), $urandom_range(1, 1000),
                       $urandom_range(0, 200000), $urandom_range(0, 200000),
                       $urandom_range(0, 200000), 1'b1);
      default: apply_setting(FAST_RATE_RST, SLOW_RATE_RST, STORM_PRES_RST,
                             RAIN_PRES_RST, FAIR_PRES_RST, 1'b0);
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int phase_count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes and alternating bit patterns
    for (int i = 0; i < 20; i++) send_sample(dir_press[i % 10], dir_temp[(i * 3) % 10]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      select_setting(phase);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        roll_segment: begin
          int n;
          n = $urandom_range(30, 300);
          // Trim the last stretch so each phase sends its share of samples
          if (n > PHASE_ITEMS - phase_count) n = PHASE_ITEMS - phase_count;
          run_segment(n);
          phase_count += n;
        end
      end
    end
    wait_idle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/btf_pkg.sv
src/btf_cell.sv
src/btf_tendency.sv
src/barometric_trend_forecaster_top.sv
verif/btf_checker.sv
verif/tb_top.sv
